>>> rtl/dde_pkg.sv
// ---------------------------------------------------------------------------
// dde_pkg
// Shared types, constants and helpers of the duplicate-suppressing
// directional event counter.
// ---------------------------------------------------------------------------
package dde_pkg;

  localparam int HISTORY_DEPTH = 128;
  localparam int COUNT_WIDTH   = 32;

  localparam int KEY_W   = 64;
  localparam int ID_W    = 32;
  localparam int FIELD_W = 32;
  localparam int TOTAL_W = 34;
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);

  // widths wide enough for the exact sums
  localparam int WIDE_W = COUNT_WIDTH + TOTAL_W;
  localparam int SET_W  = (COUNT_WIDTH + 1 > ID_W + 1) ? COUNT_WIDTH + 1 : ID_W + 1;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0]     TOTAL_MAX = '1;

  // operation codes
  localparam logic [2:0] OP_TRACKED   = 3'd0;
  localparam logic [2:0] OP_UNTRACKED = 3'd1;
  localparam logic [2:0] OP_EVIDENCE  = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_SET_TOTAL = 3'd4;

  // direction codes
  localparam logic [1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [1:0] DIR_K2F     = 2'd1;
  localparam logic [1:0] DIR_F2K     = 2'd2;

  typedef struct packed {
    logic [2:0]      op;
    logic [1:0]      direction;
    logic [ID_W-1:0] frame_id;
    logic [ID_W-1:0] keyframe_id;
    logic [ID_W-1:0] new_total;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [FIELD_W-1:0] known_to_far_count;
    logic [FIELD_W-1:0] far_to_known_count;
    logic [FIELD_W-1:0] unknown_count;
    logic [TOTAL_W-1:0] total_count;
    logic               has_evidence;
    logic               bidirectional;
  } out_item_t;

  // per-cell shift controls of the history chain
  typedef struct packed {
    logic rotate;  // every cell takes its successor, last takes the first
    logic insert;  // every cell takes its predecessor, first takes new key
  } chain_ctrl_t;

  // low field bits of a counter
  function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+FIELD_W-1:0] z;
    z = (COUNT_WIDTH + FIELD_W)'(c);
    return z[FIELD_W-1:0];
  endfunction

  // saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
  endfunction

endpackage

>>> rtl/dde_if.sv
// ---------------------------------------------------------------------------
// dde_if
// Valid/ready channels carrying requests into and results out of the block.
// ---------------------------------------------------------------------------
interface dde_in_if
  import dde_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dde_out_if
  import dde_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/dde_top.sv
// ---------------------------------------------------------------------------
// dedup_directional_event_counter_top
// Duplicate-suppressing directional event counter.
//
// Requests arrive on the item channel (valid/ready), one result per request
// leaves on the result channel. Requests: tracked event, untracked event,
// mark evidence, clear, set total.
// The key history is a ring of HISTORY_DEPTH cells. A tracked event walks
// the ring once, one cell per cycle past a single comparator, before its
// final step; every other request goes straight to its final step. A new
// request is only taken once the last one has left its final step.
// The result is registered in the final step.
// Reset (rst, synchronous) empties the history through its fill count and
// clears the counters and result valid; the cells themselves keep old data.
// The result register parts the channels: while a result waits for the
// receiver the next request is still taken and worked on, and it only
// stalls in its final step until the result register has been read.
// ---------------------------------------------------------------------------
module dedup_directional_event_counter_top
  import dde_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  dde_in_if.sink           item,
  dde_out_if.source        result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t state;

  // request held for the duration of its work
  in_item_t         req;
  logic [KEY_W-1:0] probe;

  // history bookkeeping
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] scan_cnt;
  logic              hit;
  logic [KEY_W-1:0]  head_key;
  chain_ctrl_t       chain_ctrl;

  // counters
  logic [COUNT_WIDTH-1:0] kf_cnt;
  logic [COUNT_WIDTH-1:0] fk_cnt;
  logic [COUNT_WIDTH-1:0] un_cnt;

  // result register
  logic      out_valid;
  out_item_t out_data;

  // apply-step values
  logic [COUNT_WIDTH-1:0] kf_next;
  logic [COUNT_WIDTH-1:0] fk_next;
  logic [COUNT_WIDTH-1:0] un_next;
  logic                   acc_next;
  logic                   do_insert;
  logic [SET_W-1:0]       dir_sum;
  logic [SET_W-1:0]       want;
  logic [SET_W-1:0]       rest;
  logic [WIDE_W-1:0]      sum_wide;
  logic [TOTAL_W-1:0]     total_next;
  logic                   load;
  logic                   match;

  assign probe = {req.frame_id, req.keyframe_id};

  assign item.ready   = (state == ST_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // final step may go ahead once the result register is free or being read
  assign load = (state == ST_APPLY) && (!out_valid || result.ready);

  // only the first fill cells hold live keys
  assign match = (scan_cnt < fill) && (head_key == probe);

  assign chain_ctrl.rotate = (state == ST_SCAN);
  assign chain_ctrl.insert = load && do_insert;

  dde_chain u_chain (
    .clk      (clk),
    .ctrl     (chain_ctrl),
    .ins_key  (probe),
    .head_key (head_key)
  );

  // counter update for the held request
  always_comb begin
    kf_next   = kf_cnt;
    fk_next   = fk_cnt;
    un_next   = un_cnt;
    acc_next  = 1'b1;
    do_insert = 1'b0;
    dir_sum   = SET_W'(kf_cnt) + SET_W'(fk_cnt);
    want      = SET_W'(req.new_total);
    rest      = (want > dir_sum) ? want - dir_sum : '0;

    unique case (req.op)
      OP_TRACKED, OP_UNTRACKED: begin
        if (req.op == OP_TRACKED && hit) begin
          acc_next = 1'b0;
        end else begin
          do_insert = (req.op == OP_TRACKED);
          unique case (req.direction)
            DIR_K2F: kf_next = sat_inc(kf_cnt);
            DIR_F2K: fk_next = sat_inc(fk_cnt);
            default: un_next = sat_inc(un_cnt);  // unknown and code three
          endcase
        end
      end
      OP_EVIDENCE: begin
        if (kf_cnt == '0 && fk_cnt == '0 && un_cnt == '0) begin
          un_next = COUNT_WIDTH'(1);
        end
      end
      OP_CLEAR: begin
        kf_next = '0;
        fk_next = '0;
        un_next = '0;
      end
      OP_SET_TOTAL: begin
        un_next = (rest > SET_W'(CNT_MAX)) ? CNT_MAX : rest[COUNT_WIDTH-1:0];
      end
      default: ;  // unused codes leave state alone
    endcase

    sum_wide   = WIDE_W'(kf_next) + WIDE_W'(fk_next) + WIDE_W'(un_next);
    total_next = (sum_wide > WIDE_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      scan_cnt  <= '0;
      hit       <= 1'b0;
      kf_cnt    <= '0;
      fk_cnt    <= '0;
      un_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && !load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            req      <= item.data;
            hit      <= 1'b0;
            scan_cnt <= '0;
            state    <= (item.data.op == OP_TRACKED) ? ST_SCAN : ST_APPLY;
          end
        end
        ST_SCAN: begin
          // ring turns once; cell 0 shows entry scan_cnt, newest first
          hit <= hit | match;
          if (scan_cnt == FILL_W'(HISTORY_DEPTH - 1)) begin
            scan_cnt <= '0;
            state    <= ST_APPLY;
          end else begin
            scan_cnt <= scan_cnt + FILL_W'(1);
          end
        end
        ST_APPLY: begin
          if (load) begin
            kf_cnt <= kf_next;
            fk_cnt <= fk_next;
            un_cnt <= un_next;
            if (req.op == OP_CLEAR) begin
              fill <= '0;
            end else if (do_insert && fill != FILL_W'(HISTORY_DEPTH)) begin
              fill <= fill + FILL_W'(1);
            end
            out_valid                   <= 1'b1;
            out_data.accepted           <= acc_next;
            out_data.known_to_far_count <= to_field(kf_next);
            out_data.far_to_known_count <= to_field(fk_next);
            out_data.unknown_count      <= to_field(un_next);
            out_data.total_count        <= total_next;
            out_data.has_evidence       <= (total_next != '0);
            out_data.bidirectional      <= (kf_next != '0) && (fk_next != '0);
            state                       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // history never holds more keys than cells
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill above depth");

  // a new result only appears after a final step
  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_APPLY))
    else $error("result raised outside final step");

  // duplicate leaves every counter untouched
  a_dup_no_change: assert property (@(posedge clk) disable iff (rst)
    (load && req.op == OP_TRACKED && hit) |=>
      ($stable(kf_cnt) && $stable(fk_cnt) && $stable(un_cnt) && $stable(fill)))
    else $error("duplicate changed state");

  // scan counter rests at zero outside the ring walk
  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (scan_cnt == '0))
    else $error("scan counter not parked");

endmodule

>>> rtl/dde_cell.sv
// ---------------------------------------------------------------------------
// dde_cell
// One history entry; takes a neighbour's key on rotate or insert.
// ---------------------------------------------------------------------------
module dde_cell
  import dde_pkg::*;
(
  input  logic             clk,
  input  chain_ctrl_t      ctrl,
  input  logic [KEY_W-1:0] from_prev,
  input  logic [KEY_W-1:0] from_next,
  output logic [KEY_W-1:0] key
);

  always_ff @(posedge clk) begin
    priority if (ctrl.insert) begin
      key <= from_prev;
    end else if (ctrl.rotate) begin
      key <= from_next;
    end else begin
      key <= key;
    end
  end

endmodule

>>> rtl/dde_chain.sv
// ---------------------------------------------------------------------------
// dde_chain
// Ring of history cells; newest key at cell 0, oldest falls off the end.
// ---------------------------------------------------------------------------
module dde_chain
  import dde_pkg::*;
(
  input  logic             clk,
  input  chain_ctrl_t      ctrl,
  input  logic [KEY_W-1:0] ins_key,
  output logic [KEY_W-1:0] head_key
);

  logic [KEY_W-1:0] keys [HISTORY_DEPTH];

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic [KEY_W-1:0] next_key;

    if (i == 0) begin : g_first
      assign prev_key = ins_key;
    end else begin : g_mid
      assign prev_key = keys[i-1];
    end

    if (i == HISTORY_DEPTH - 1) begin : g_last
      assign next_key = keys[0];
    end else begin : g_inner
      assign next_key = keys[i+1];
    end

    dde_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .from_prev (prev_key),
      .from_next (next_key),
      .key       (keys[i])
    );
  end

  assign head_key = keys[0];

endmodule

>>> tb/sv/dedup_directional_event_counter_top_tb.sv
// ---------------------------------------------------------------------------
// dedup_directional_event_counter_top_tb
// Self-checking testbench of the duplicate-suppressing directional event
// counter. A behavioural model in this file predicts every result; directed
// tests cover the corner cases, then random traffic runs under varying idle
// patterns on both channels and one long result hold-off.
// ---------------------------------------------------------------------------
module dedup_directional_event_counter_top_tb;
  import dde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // op codes the block does not define, and the spare direction code
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam logic [1:0] DIR_SPARE       = 2'd3;

  localparam int KEY_POOL_DEPTH = 2 * HISTORY_DEPTH;

  logic clk = 1'b0;
  logic rst;

  dde_in_if  item_ch ();
  dde_out_if res_ch ();

  dedup_directional_event_counter_top u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // model state: key history in arrival order plus the three counters
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]       key_history[$];
  logic [COUNT_WIDTH-1:0] kf_count;
  logic [COUNT_WIDTH-1:0] fk_count;
  logic [COUNT_WIDTH-1:0] unk_count;

  out_item_t        expected_results[$];
  logic [KEY_W-1:0] key_pool[$];  // recently used keys, for duplicates
  int               mismatch_count = 0;

  // idle percentages of each side and the pending long hold-off
  int src_idle_pct    = 0;
  int sink_idle_pct   = 0;
  int hold_off_cycles = 0;

  function automatic void bump_counter(logic [1:0] dir);
    if (dir == DIR_K2F) begin
      if (kf_count != CNT_MAX) kf_count++;
    end else if (dir == DIR_F2K) begin
      if (fk_count != CNT_MAX) fk_count++;
    end else begin
      // unknown and the spare code both land here
      if (unk_count != CNT_MAX) unk_count++;
    end
  endfunction

  // applies one request to the model and returns the result it should give
  function automatic out_item_t count_event(in_item_t it);
    out_item_t        r;
    logic [KEY_W-1:0] key;
    logic [COUNT_WIDTH:0] dir_sum;
    bit               seen;
    key = {it.frame_id, it.keyframe_id};
    seen = 1'b0;
    r = '0;
    r.accepted = 1'b1;
    case (it.op)
      OP_TRACKED: begin
        foreach (key_history[i]) if (key_history[i] == key) seen = 1'b1;
        if (seen) begin
          r.accepted = 1'b0;
        end else begin
          if (key_history.size() == HISTORY_DEPTH) key_history.delete(0);
          key_history = {key_history, key};
          bump_counter(it.direction);
        end
      end
      OP_UNTRACKED: bump_counter(it.direction);
      OP_EVIDENCE: begin
        if (kf_count == '0 && fk_count == '0 && unk_count == '0) begin
          unk_count = COUNT_WIDTH'(1);
        end
      end
      OP_CLEAR: begin
        kf_count = '0;
        fk_count = '0;
        unk_count = '0;
        key_history.delete();
      end
      OP_SET_TOTAL: begin
        dir_sum = {1'b0, kf_count} + {1'b0, fk_count};
        unk_count = ((COUNT_WIDTH + 1)'(it.new_total) > dir_sum) ?
                    COUNT_WIDTH'((COUNT_WIDTH + 1)'(it.new_total) - dir_sum) : '0;
      end
      default: ;
    endcase
    r.known_to_far_count = kf_count;
    r.far_to_known_count = fk_count;
    r.unknown_count      = unk_count;
    // three 32-bit counters cannot overflow the 34-bit total
    r.total_count   = TOTAL_W'(kf_count) + TOTAL_W'(fk_count) + TOTAL_W'(unk_count);
    r.has_evidence  = (r.total_count != '0);
    r.bidirectional = (kf_count != '0) && (fk_count != '0);
    return r;
  endfunction

  function automatic in_item_t make_request(logic [2:0] op, logic [1:0] dir,
                                            logic [KEY_W-1:0] key,
                                            logic [ID_W-1:0] total);
    in_item_t it;
    it.op          = op;
    it.direction   = dir;
    it.frame_id    = key[KEY_W-1:ID_W];
    it.keyframe_id = key[ID_W-1:0];
    it.new_total   = total;
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void remember_key(logic [KEY_W-1:0] key);
    key_pool = {key_pool, key};
    if (key_pool.size() > KEY_POOL_DEPTH) key_pool.delete(0);
  endfunction

  // mostly tracked events, reusing recent keys often enough to hit both
  // duplicates and keys already evicted from the history
  function automatic in_item_t random_request();
    in_item_t         it;
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    pick = $urandom_range(99);
    key = fresh_key();
    it = make_request(OP_TRACKED, 2'($urandom_range(3)), key, $urandom());
    if (pick < 58) begin
      if (key_pool.size() != 0 && $urandom_range(4) < 2) begin
        key = key_pool[$urandom_range(key_pool.size() - 1)];
        it.frame_id    = key[KEY_W-1:ID_W];
        it.keyframe_id = key[ID_W-1:0];
      end else begin
        remember_key(key);
      end
    end else if (pick < 78) begin
      it.op = OP_UNTRACKED;
    end else if (pick < 83) begin
      it.op = OP_EVIDENCE;
    end else if (pick < 84) begin
      it.op = OP_CLEAR;
    end else if (pick < 94) begin
      it.op = OP_SET_TOTAL;
      case ($urandom_range(2))
        0: it.new_total = $urandom();
        1: it.new_total = $urandom_range(int'(kf_count) + int'(fk_count) + 20);
        default: it.new_total = '1;
      endcase
    end else begin
      it.op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: called at a falling edge, returns at a falling edge once
  // the request has been taken; valid only drops when the next call idles
  // ---------------------------------------------------------------------------
  task automatic send_request(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    expected_results = {expected_results, count_event(it)};
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready is redrawn every falling edge; a long hold-off, when
  // one is asked for, is counted down here
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic check_field(string field, logic [TOTAL_W-1:0] want,
                             logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // every result taken is held against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %p",
                 $time, res_ch.data);
        mismatch_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        check_field("accepted", TOTAL_W'(want.accepted),
                    TOTAL_W'(res_ch.data.accepted));
        check_field("known_to_far_count", TOTAL_W'(want.known_to_far_count),
                    TOTAL_W'(res_ch.data.known_to_far_count));
        check_field("far_to_known_count", TOTAL_W'(want.far_to_known_count),
                    TOTAL_W'(res_ch.data.far_to_known_count));
        check_field("unknown_count", TOTAL_W'(want.unknown_count),
                    TOTAL_W'(res_ch.data.unknown_count));
        check_field("total_count", want.total_count, res_ch.data.total_count);
        check_field("has_evidence", TOTAL_W'(want.has_evidence),
                    TOTAL_W'(res_ch.data.has_evidence));
        check_field("bidirectional", TOTAL_W'(want.bidirectional),
                    TOTAL_W'(res_ch.data.bidirectional));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // evidence only sets unknown when every counter is still zero
  task automatic test_evidence_and_clear();
    send_request(make_request(OP_EVIDENCE, DIR_UNKNOWN, '0, '0));
    send_request(make_request(OP_EVIDENCE, DIR_K2F, '1, '1));
    send_request(make_request(OP_CLEAR, DIR_F2K, '0, '1));
  endtask

  // duplicates are refused, the spare direction counts as unknown, and a
  // clear empties the history so an old key is taken again
  task automatic test_tracked_duplicates();
    send_request(make_request(OP_TRACKED, DIR_K2F, '0, '0));
    send_request(make_request(OP_TRACKED, DIR_F2K, '0, '1));
    send_request(make_request(OP_TRACKED, DIR_F2K, '1, '0));
    send_request(make_request(OP_TRACKED, DIR_UNKNOWN, {32'h0, 32'hffff_ffff}, '0));
    send_request(make_request(OP_TRACKED, DIR_SPARE, {32'hffff_ffff, 32'h0}, '0));
    send_request(make_request(OP_CLEAR, DIR_UNKNOWN, '0, '0));
    send_request(make_request(OP_TRACKED, DIR_K2F, '0, '0));
  endtask

  // total below, at and far above the directional sum
  task automatic test_set_total();
    send_request(make_request(OP_SET_TOTAL, DIR_UNKNOWN, '1, '0));
    send_request(make_request(OP_SET_TOTAL, DIR_UNKNOWN, '0, 32'd1));
    send_request(make_request(OP_UNTRACKED, DIR_F2K, '0, '0));
    send_request(make_request(OP_SET_TOTAL, DIR_K2F, '1, 32'd100));
    send_request(make_request(OP_SET_TOTAL, DIR_F2K, '0, '1));
  endtask

  // unknown pinned at its maximum must not wrap; totals pass 2^32
  task automatic test_saturation();
    send_request(make_request(OP_CLEAR, DIR_UNKNOWN, '0, '0));
    send_request(make_request(OP_SET_TOTAL, DIR_UNKNOWN, '0, '1));
    send_request(make_request(OP_UNTRACKED, DIR_UNKNOWN, '1, '1));
    send_request(make_request(OP_UNTRACKED, DIR_SPARE, '0, '0));
    send_request(make_request(OP_TRACKED, DIR_K2F, fresh_key(), '1));
    send_request(make_request(OP_UNTRACKED, DIR_F2K, fresh_key(), '0));
  endtask

  // undefined op codes change nothing
  task automatic test_unused_ops();
    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++) begin
      send_request(make_request(3'(op), 2'($urandom_range(3)), fresh_key(), $urandom()));
    end
  endtask

  // fill the history, then check the oldest key only drops out on eviction
  task automatic test_history_eviction();
    logic [KEY_W-1:0] keys[HISTORY_DEPTH];
    send_request(make_request(OP_CLEAR, DIR_UNKNOWN, '0, '0));
    foreach (keys[i]) begin
      keys[i] = fresh_key();
      remember_key(keys[i]);
      send_request(make_request(OP_TRACKED, 2'($urandom_range(3)), keys[i], $urandom()));
    end
    send_request(make_request(OP_TRACKED, DIR_K2F, keys[0], $urandom()));
    send_request(make_request(OP_TRACKED, DIR_F2K, fresh_key(), $urandom()));
    send_request(make_request(OP_TRACKED, DIR_K2F, keys[0], $urandom()));
    send_request(make_request(OP_TRACKED, DIR_F2K, keys[2], $urandom()));
    send_request(make_request(OP_TRACKED, DIR_UNKNOWN, keys[1], $urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // random tests
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(int n, int src_pct, int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (n) send_request(random_request());
  endtask

  // results held back for a long stretch while requests keep coming, so the
  // block fills up and stops taking them
  task automatic test_result_hold_off();
    src_idle_pct    = 0;
    sink_idle_pct   = 0;
    hold_off_cycles = 4 * HISTORY_DEPTH;
    repeat (12) send_request(random_request());
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    kf_count  = '0;
    fk_count  = '0;
    unk_count = '0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    res_ch.ready  = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_evidence_and_clear();
    test_tracked_duplicates();
    test_set_total();
    test_saturation();
    test_unused_ops();
    test_history_eviction();

    test_random_traffic(300, 8, 88);
    test_random_traffic(300, 88, 8);
    test_result_hold_off();
    test_random_traffic(300, 0, 0);

    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // room for a stray late result to show up
    repeat (2 * HISTORY_DEPTH + 10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("dedup_directional_event_counter_top_tb: PASS");
    end else begin
      $display("dedup_directional_event_counter_top_tb: FAIL");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("dedup_directional_event_counter_top_tb: FAIL");
    $finish;
  end

endmodule
